/* src/sirb_pkg.sv */
// Shared types and codes for the sorted in-order release buffer.
// Used by the cell, the top level, the port checker and the testbench; no dependencies.
package sirb_pkg;

    localparam int ValW = 16;

    typedef logic [ValW-1:0] val_t;

    // Result codes
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_REJECT       = 3'd1,
        ST_FULL         = 3'd2,
        ST_NOT_SMALLEST = 3'd3,
        ST_EMPTY        = 3'd4
    } status_t;

    // Request codes
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Register indexes on the configuration channel
    localparam logic CFG_RANGE_START = 1'b0;
    localparam logic CFG_RANGE_END   = 1'b1;

    // Command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
        val_t value;
    } cell_cmd_t;

    // What a cell shows its neighbors and the top level
    typedef struct packed {
        logic occ;    // cell holds a value
        logic above;  // empty, or holds a value >= the request value
        logic dup;    // first cell at or above the request value, and equal to it
        val_t data;
    } cell_view_t;

    // Boundary views: below the release end and past the far end
    localparam cell_view_t EDGE_LOW  = '{occ: 1'b1, above: 1'b0, dup: 1'b0, data: '0};
    localparam cell_view_t EDGE_HIGH = '{occ: 1'b0, above: 1'b1, dup: 1'b0, data: '0};

endpackage

/* src/sirb_cell.sv */
// One storage cell of the sorted chain; cell 0 is the release end.
// Depends on sirb_pkg.
module sirb_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sirb_pkg::cell_cmd_t   cmd,
    input  sirb_pkg::cell_view_t  lower,
    input  sirb_pkg::cell_view_t  upper,
    output sirb_pkg::cell_view_t  view
);
    import sirb_pkg::*;

    logic occ_reg;
    logic occ_next;
    val_t data_reg;
    val_t data_next;
    logic above;

    // Compare against the request value
    assign above = !occ_reg || (data_reg >= cmd.value);

    assign view.occ   = occ_reg;
    assign view.above = above;
    assign view.dup   = above && !lower.above && occ_reg && (data_reg == cmd.value);
    assign view.data  = data_reg;

    // Shift up on insert, shift down on remove, otherwise hold
    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        if (cmd.insert)
        begin
            if (lower.above)
            begin
                occ_next  = lower.occ;
                data_next = lower.data;
            end
            else if (above)
            begin
                occ_next  = 1'b1;
                data_next = cmd.value;
            end
        end
        else if (cmd.remove)
        begin
            occ_next  = upper.occ;
            data_next = upper.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

/* src/sorted_inorder_release_buffer_core.sv */
// Sorted in-order release buffer: a chain of DEPTH cells kept in ascending order.
// Each accepted request's result beat is registered and appears the next cycle.
// One request per cycle unless stalled; all cells compare and shift in parallel.
// Reset (async, active low) empties the chain, clears next-expected and range
// start to 0 and sets range end to 65535. Depends on sirb_pkg and sirb_cell.
module sorted_inorder_release_buffer_core #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  sirb_pkg::val_t      value,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output sirb_pkg::val_t      released_value,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  sirb_pkg::val_t      cfg_data
);
    import sirb_pkg::*;

    cell_view_t       views [DEPTH];
    cell_cmd_t        cmd;
    logic [DEPTH-1:0] dup_vec;

    val_t    next_expected_reg;
    val_t    next_expected_next;
    val_t    range_end_reg;
    val_t    range_end_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    status_t status_reg;
    status_t status_next;
    val_t    released_reg;
    val_t    released_next;

    logic accept;
    logic cfg_write;
    logic full;
    logic empty;
    logic dup_any;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;

    // Build the cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_view_t lower_view;
        cell_view_t upper_view;

        if (i == 0)
        begin : g_low
            assign lower_view = EDGE_LOW;
        end
        else
        begin : g_mid_low
            assign lower_view = views[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_high
            assign upper_view = EDGE_HIGH;
        end
        else
        begin : g_mid_high
            assign upper_view = views[i+1];
        end

        sirb_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .lower (lower_view),
            .upper (upper_view),
            .view  (views[i])
        );

        assign dup_vec[i] = views[i].dup;
    end

    assign full    = views[DEPTH-1].occ;
    assign empty   = !views[0].occ;
    assign dup_any = |dup_vec;

    // Decide the request outcome and drive the chain
    always_comb
    begin
        cmd.value          = value;
        cmd.insert         = 1'b0;
        cmd.remove         = 1'b0;
        next_expected_next = next_expected_reg;
        range_end_next     = range_end_reg;
        status_next        = status_reg;
        released_next      = released_reg;
        out_valid_next     = out_valid_reg && out_stall;

        if (accept)
        begin
            out_valid_next = 1'b1;
            released_next  = '0;
            case (req_type)
                REQ_ADD:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if ((value < next_expected_reg) || (value > range_end_reg) || dup_any)
                    begin
                        status_next = ST_REJECT;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        cmd.insert  = 1'b1;
                    end
                end
                REQ_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (views[0].data == value)
                    begin
                        status_next        = ST_OK;
                        cmd.remove         = 1'b1;
                        released_next      = value;
                        next_expected_next = val_t'(next_expected_reg + val_t'(1));
                    end
                    else
                    begin
                        status_next = ST_NOT_SMALLEST;
                    end
                end
                default:
                begin
                    status_next = ST_NOT_SMALLEST;
                end
            endcase
        end

        // Register writes
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_RANGE_START: next_expected_next = cfg_data;
                CFG_RANGE_END:   range_end_next     = cfg_data;
                default:         range_end_next     = range_end_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_expected_reg <= '0;
            range_end_reg     <= '1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            next_expected_reg <= next_expected_next;
            range_end_reg     <= range_end_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Hold the result beat
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        released_reg <= released_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign released_value = released_reg;

endmodule

/* src/sirb_port_checker.sv */
// Port-level checks on the sorted in-order release buffer, bound to the top level.
// Depends on sirb_pkg and sorted_inorder_release_buffer_core.
module sirb_port_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input logic [2:0]     status,
    input sirb_pkg::val_t released_value
);
    import sirb_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(released_value))
        else $error("result beat changed while stalled");

    // Every accepted request yields a result beat next cycle
    a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted request gave no result");

    // Requests stall only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled without a pending result");

    // A failed request always shows a zero released value
    a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> released_value == '0)
        else $error("value released on a failed request");

    // Status stays within the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_REJECT) || (status == ST_FULL)
                      || (status == ST_NOT_SMALLEST) || (status == ST_EMPTY))
        else $error("undefined status code");

endmodule

bind sorted_inorder_release_buffer_core sirb_port_checker u_sirb_port_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .released_value (released_value)
);

/* tb/sorted_inorder_release_buffer_core_test.sv */
// Self-checking testbench for sorted_inorder_release_buffer_core: directed corner cases,
// then randomized add/remove traffic under several range settings with random stalls.
// Depends on sirb_pkg and the core RTL only.
module sorted_inorder_release_buffer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sirb_pkg::*;

    localparam int DEPTH = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int IDLE_PCT = 23;
    localparam int WINDOW = 47;

    typedef struct {
        status_t st;
        val_t    rel;
    } result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       req_type = REQ_ADD;
    val_t       value = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] status;
    val_t       released_value;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = CFG_RANGE_START;
    val_t       cfg_data = '0;

    // Shadow state of the buffer
    val_t    held [DEPTH];
    int      held_count = 0;
    val_t    next_exp = '0;
    val_t    range_hi = 16'hFFFF;

    result_t pending_results [$];
    result_t head_exp;
    bit      calm = 1'b0;
    int      mismatches = 0;
    int      sent_count = 0;
    int      result_count = 0;
    int      setting_count = 0;
    int      status_hits [5] = '{default: 0};
    int      quiet_cycles = 0;

    sorted_inorder_release_buffer_core #(
        .DEPTH(DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .released_value (released_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the shadow buffer and return the result it should produce
    function automatic result_t apply_request(logic rt, val_t v);
        result_t r;
        int      pos;
        bit      dup;
        r.st = ST_OK;
        r.rel = '0;
        pos = held_count;
        dup = 1'b0;
        if (rt == REQ_ADD)
        begin
            if (held_count >= DEPTH)
                r.st = ST_FULL;
            else if (v < next_exp || v > range_hi)
                r.st = ST_REJECT;
            else
            begin
                // find the slot: entries run high to low toward the release end
                for (int i = 0; i < held_count; i++)
                begin
                    if (v == held[i])
                    begin
                        dup = 1'b1;
                        break;
                    end
                    if (v > held[i])
                    begin
                        pos = i;
                        break;
                    end
                end
                if (dup)
                    r.st = ST_REJECT;
                else
                begin
                    for (int i = held_count; i > pos; i--)
                        held[i] = held[i - 1];
                    held[pos] = v;
                    held_count++;
                end
            end
        end
        else if (held_count == 0)
            r.st = ST_EMPTY;
        else if (held[held_count - 1] == v)
        begin
            held_count--;
            next_exp = next_exp + 1'b1;
            r.rel = v;
        end
        else
            r.st = ST_NOT_SMALLEST;
        return r;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: MISMATCH %s", $realtime, msg);
    endfunction

    // Send one request beat; hold the payload while stalled
    task automatic send_req(logic rt, val_t v);
        result_t r;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        req_type <= rt;
        value <= v;
        do @(posedge clk); while (in_stall);
        r = apply_request(rt, v);
        pending_results.insert(pending_results.size(), r);
        status_hits[r.st]++;
        sent_count++;
    endtask

    // Drop the request valid and wait for every pending result to come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write range start (also reloads next-expected), then range end
    task automatic write_ranges(val_t lo, val_t hi);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_RANGE_START;
        cfg_data <= lo;
        do @(posedge clk); while (!cfg_ready);
        next_exp = lo;
        cfg_index <= CFG_RANGE_END;
        cfg_data <= hi;
        do @(posedge clk); while (!cfg_ready);
        range_hi = hi;
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    function automatic val_t any_value();
        return val_t'($urandom_range(0, 16'hFFFF));
    endfunction

    // Mostly well-formed traffic: in-window adds and in-order releases, plus noise
    task automatic run_mixed(int n_items, int add_pct);
        int   roll;
        int   span;
        val_t v;
        logic rt;
        for (int k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(0, 99);
            span = int'(range_hi) - int'(next_exp);
            if (roll < add_pct)
            begin
                rt = REQ_ADD;
                roll = $urandom_range(0, 99);
                if (roll < 70 && span >= 0)
                    v = next_exp + val_t'($urandom_range(0, span < WINDOW ? span : WINDOW));
                else if (roll < 82 && held_count > 0)
                    v = held[$urandom_range(0, held_count - 1)];
                else if (roll < 86)
                    v = range_hi;
                else if (roll < 90)
                    v = range_hi + 1'b1;
                else if (roll < 94)
                    v = next_exp - 1'b1;
                else
                    v = any_value();
            end
            else
            begin
                rt = REQ_REMOVE;
                roll = $urandom_range(0, 99);
                if (roll < 80 && held_count > 0)
                    v = held[held_count - 1];
                else if (roll < 90 && held_count > 0)
                    v = held[$urandom_range(0, held_count - 1)];
                else
                    v = any_value();
            end
            send_req(rt, v);
        end
    endtask

    // Empty remove, extremes of the value, duplicate, wrong value, below next-expected
    task automatic test_basic_cases();
        send_req(REQ_REMOVE, 16'h0000);
        send_req(REQ_ADD, 16'hFFFF);
        send_req(REQ_ADD, 16'h0000);
        send_req(REQ_ADD, 16'h0000);
        send_req(REQ_REMOVE, 16'hFFFF);
        send_req(REQ_REMOVE, 16'h0000);
        send_req(REQ_ADD, 16'h0000);
        settle();
    endtask

    // Fill every slot, then an add that would otherwise be legal must report full
    task automatic test_full_buffer();
        for (int k = 2; k <= 16; k++)
            send_req(REQ_ADD, val_t'(k));
        send_req(REQ_ADD, 16'h0001);
        settle();
    endtask

    // Start next-expected at the top so one release wraps it to zero
    task automatic test_counter_wrap();
        write_ranges(16'hFFFF, 16'hFFFF);
        send_req(REQ_REMOVE, 16'h0002);
        send_req(REQ_ADD, 16'h0000);
        send_req(REQ_REMOVE, 16'h0000);
        settle();
    endtask

    // Range end below next-expected refuses every add
    task automatic test_inverted_range();
        write_ranges(16'h0005, 16'h0003);
        send_req(REQ_ADD, 16'h0004);
        send_req(REQ_ADD, 16'h1234);
        settle();
    endtask

    // Random traffic over several range settings, extremes included
    task automatic test_random_phases();
        val_t lo;
        val_t hi;
        int   add_pct;
        for (int ph = 0; ph < 6; ph++)
        begin
            calm = 1'b0;
            case (ph)
                0:
                begin
                    lo = 16'h0000;
                    hi = 16'hFFFF;
                    add_pct = 60;
                end
                1:
                begin
                    lo = val_t'($urandom_range(0, 16'hFF00));
                    hi = lo + val_t'($urandom_range(16, 240));
                    add_pct = 55;
                    calm = 1'b1;
                end
                2:
                begin
                    lo = 16'hFFF0;
                    hi = 16'hFFFF;
                    add_pct = 55;
                end
                3:
                begin
                    lo = 16'd200;
                    hi = 16'd100;
                    add_pct = 40;
                end
                4:
                begin
                    lo = any_value();
                    hi = 16'hFFFF;
                    add_pct = 35;
                end
                default:
                begin
                    lo = 16'h0000;
                    hi = 16'h0000;
                    add_pct = 50;
                end
            endcase
            write_ranges(lo, hi);
            run_mixed(220, add_pct);
            settle();
        end
        calm = 1'b0;
    endtask

    // Result-side backpressure
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    // Compare each accepted result beat against the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (pending_results.size() == 0)
                note_mismatch($sformatf("unexpected result beat status %0d released %h",
                                        status, released_value));
            else
            begin
                head_exp = pending_results.pop_front();
                if (status !== head_exp.st)
                    note_mismatch($sformatf("status expected %0d (%s) got %0d",
                                            head_exp.st, head_exp.st.name(), status));
                if (released_value !== head_exp.rel)
                    note_mismatch($sformatf("released_value expected %h got %h",
                                            head_exp.rel, released_value));
            end
        end
    end

    // Abort if no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: timeout, no beat for %0d cycles", $realtime, QUIET_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_cases();
        test_full_buffer();
        test_counter_wrap();
        test_inverted_range();
        test_random_phases();
        settle();
        repeat (4) @(posedge clk);
        $display("Ran %0d requests, checked %0d results across %0d range settings",
                 sent_count, result_count, setting_count);
        $display("Outcomes: ok %0d, rejected %0d, full %0d, not smallest %0d, empty %0d",
                 status_hits[ST_OK], status_hits[ST_REJECT], status_hits[ST_FULL],
                 status_hits[ST_NOT_SMALLEST], status_hits[ST_EMPTY]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
